// File: hw/rtl/fdt_pkg.sv
package fdt_pkg;

   localparam int unsigned FracWidth  = 23;
   localparam int unsigned ExpWidth   = 8;
   localparam int unsigned MantWidth  = FracWidth + 1;
   // quotient bits resolved per pipeline stage of the divide array
   localparam int unsigned BitsPerStage = 4;
   localparam int unsigned NumStages    = MantWidth / BitsPerStage;
   // input register plus one register per divide stage
   localparam int unsigned Depth        = NumStages + 1;

   localparam logic [31:0] QnanBits = 32'h7FC0_0000;
   localparam logic [31:0] PosInf   = 32'h7F80_0000;
   localparam logic [31:0] NegInf   = 32'hFF80_0000;
   localparam logic [ExpWidth-1:0] ExpMax = 8'hFF;
   localparam logic [9:0] Bias = 10'd127;

   // control that travels with each item
   typedef struct packed {
      logic        special;      // result already known
      logic [31:0] special_bits;
      logic        sign;
      logic [9:0]  exp;          // signed biased exponent, before normalize
   } ctrl_type;

   // partial remainder state of the restoring divider
   typedef struct packed {
      logic [MantWidth:0]   rem;
      logic [MantWidth-1:0] div;
      logic [MantWidth-1:0] quo;
   } div_type;

endpackage

// File: hw/rtl/fdt_if.sv
interface fdt_if;
   logic        valid;
   logic        ready;
   logic [31:0] bits_a;
   logic [31:0] bits_b;
   modport source (output valid, bits_a, bits_b, input ready);
   modport sink (input valid, bits_a, bits_b, output ready);
endinterface

// File: hw/rtl/fdt_rsp_if.sv
interface fdt_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] quotient_bits;
   modport source (output valid, quotient_bits, input ready);
   modport sink (input valid, quotient_bits, output ready);
endinterface

// File: hw/rtl/fdt_unpack.sv
module fdt_unpack
   import fdt_pkg::*;
(
   input  logic [31:0] dividend_bits,
   input  logic [31:0] divisor_bits,
   output ctrl_type    ctrl,
   output div_type     div
);
   logic x_zero, y_zero, x_nan;
   logic [ExpWidth-1:0] xe, ye;

   always_comb begin
      x_zero = (dividend_bits[30:0] == 31'd0);
      y_zero = (divisor_bits[30:0] == 31'd0);
      xe = dividend_bits[30:23];
      ye = divisor_bits[30:23];
      x_nan = (xe == ExpMax) && (dividend_bits[22:0] != 23'd0);
      ctrl.special = x_zero || y_zero;
      if (y_zero && x_zero) ctrl.special_bits = QnanBits;
      else if (y_zero) ctrl.special_bits = (!dividend_bits[31] && !x_nan) ? PosInf : NegInf;
      else ctrl.special_bits = 32'd0;
      ctrl.sign = dividend_bits[31] ^ divisor_bits[31];
      ctrl.exp = {2'b00, xe} - {2'b00, ye} + Bias;
      // numerator = mantA << 23; first step compares mantA against mantB
      div.rem = {1'b0, 1'b1, dividend_bits[22:0]};
      div.div = {1'b1, divisor_bits[22:0]};
      div.quo = '0;
   end
endmodule

// File: hw/rtl/fdt_div_stage.sv
module fdt_div_stage
   import fdt_pkg::*;
(
   input  div_type d_in,
   input  logic    last,
   output div_type d_out
);
   // BitsPerStage restoring steps; rem < 2*div holds on entry to each step
   always_comb begin
      logic [MantWidth:0] r;
      logic [MantWidth:0] diff;
      logic [MantWidth-1:0] q;
      r = d_in.rem;
      q = d_in.quo;
      for (int i = 0; i < BitsPerStage; i++) begin
         diff = r - {1'b0, d_in.div};
         if (!diff[MantWidth]) begin
            q = {q[MantWidth-2:0], 1'b1};
            r = diff;
         end else begin
            q = {q[MantWidth-2:0], 1'b0};
         end
         if (!(last && i == BitsPerStage - 1)) r = {r[MantWidth-1:0], 1'b0};
      end
      d_out.rem = r;
      d_out.div = d_in.div;
      d_out.quo = q;
   end
endmodule

// File: hw/rtl/fdt_pack.sv
module fdt_pack
   import fdt_pkg::*;
(
   input  ctrl_type             ctrl,
   input  logic [MantWidth-1:0] quo,
   output logic [31:0]          quotient_bits
);
   logic [9:0] e;
   logic [MantWidth-1:0] q;

   always_comb begin
      q = quo;
      e = ctrl.exp;
      if (!quo[MantWidth-1]) begin
         q = {quo[MantWidth-2:0], 1'b0};
         e = ctrl.exp - 10'd1;
      end
      if (ctrl.special) quotient_bits = ctrl.special_bits;
      else if (e[9]) quotient_bits = {ctrl.sign, 31'd0};
      else if (e >= 10'd255) quotient_bits = {ctrl.sign, ExpMax, 23'd0};
      else if (e == 10'd0) quotient_bits = {ctrl.sign, 31'd0};
      else quotient_bits = {ctrl.sign, e[7:0], q[FracWidth-1:0]};
   end
endmodule

// File: hw/rtl/float32_divider_truncating.sv
// Pipelined single-precision divider without rounding. One division enters per
// cycle; the pipeline is an input register, six restoring-divide stages of four
// quotient bits each, and the output register. The whole pipeline advances
// together, so a stall at the result port holds every stage and loses nothing.
module float32_divider_truncating
   import fdt_pkg::*;
(
   input logic clock,
   input logic reset,
   fdt_if.sink       req,
   fdt_rsp_if.source rsp
);
   logic     valid_ff [Depth+1];
   ctrl_type ctrl_ff  [Depth];
   div_type  div_ff   [Depth];
   logic [31:0] out_ff;
   logic     advance;
   ctrl_type ctrl_in;
   div_type  div_in;
   div_type  stage_out [NumStages];
   logic [31:0] bits_in;

   assign advance   = !valid_ff[Depth] || rsp.ready;
   assign req.ready = advance;
   assign rsp.valid = valid_ff[Depth];
   assign rsp.quotient_bits = out_ff;

   fdt_unpack u_unpack (
      .dividend_bits(req.bits_a), .divisor_bits(req.bits_b),
      .ctrl(ctrl_in), .div(div_in));

   for (genvar s = 0; s < NumStages; s++) begin : g_stage
      fdt_div_stage u_stage (
         .d_in(div_ff[s]), .last(s == NumStages - 1), .d_out(stage_out[s]));
   end

   fdt_pack u_pack (
      .ctrl(ctrl_ff[Depth-1]), .quo(div_ff[Depth-1].quo), .quotient_bits(bits_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= Depth; i++) valid_ff[i] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= req.valid;
         for (int i = 1; i <= Depth; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctrl_ff[0] <= ctrl_in;
         div_ff[0]  <= div_in;
         for (int i = 1; i < Depth; i++) ctrl_ff[i] <= ctrl_ff[i-1];
         for (int i = 1; i < Depth; i++) div_ff[i] <= stage_out[i-1];
         out_ff <= bits_in;
      end
   end

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.quotient_bits))
      else $error("result changed under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("pipeline stalled with empty output");
   a_norm: assert property (@(posedge clock) disable iff (reset)
      valid_ff[Depth-1] && !ctrl_ff[Depth-1].special |->
      div_ff[Depth-1].quo[MantWidth-1] || div_ff[Depth-1].quo[MantWidth-2])
      else $error("mantissa quotient out of range");
`endif
endmodule
